### design/urdc_pkg.sv
// Shared types and constants for the ultrasonic range digit controller.
// No dependencies; the control, output-buffer and top-level files use it.
package urdc_pkg;

   localparam int TICK_WIDTH = 16;
   localparam int UNIT_WIDTH = 8;
   localparam int DIGIT_WIDTH = 4;
   localparam int SEG_WIDTH = 8;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int REQ_DATA_WIDTH = 8;
   localparam int RSP_DATA_WIDTH = 16;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TRIGGER_TICKS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HOLDOFF_TICKS = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TICKS_PER_UNIT = 2'd2;

   localparam logic [TICK_WIDTH-1:0] TRIGGER_TICKS_RESET = 16'd10;
   localparam logic [TICK_WIDTH-1:0] HOLDOFF_TICKS_RESET = 16'd60000;
   localparam logic [UNIT_WIDTH-1:0] TICKS_PER_UNIT_RESET = 8'd56;

   localparam logic [DIGIT_WIDTH-1:0] UNIT_MAX = 4'd10;
   localparam logic [SEG_WIDTH-1:0] DOT_ONLY = 8'h80;

   // Measurement cycle phases, one-hot.
   typedef enum logic [3:0] {
      PH_TRIGGER = 4'b0001,
      PH_WAIT    = 4'b0010,
      PH_MEASURE = 4'b0100,
      PH_HOLDOFF = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [TICK_WIDTH-1:0] trigger_ticks;
      logic [TICK_WIDTH-1:0] holdoff_ticks;
      logic [UNIT_WIDTH-1:0] ticks_per_unit;
   } cfg_type;

   typedef struct packed {
      logic                 measure_done;
      logic                 led_on;
      logic [SEG_WIDTH-1:0] segment_bits;
      logic                 trigger_level;
   } rsp_type;

   // Seven-segment pattern for one decimal digit, bit0 is segment a.
   function automatic logic [SEG_WIDTH-1:0] digit_pattern(input logic [DIGIT_WIDTH-1:0] digit);
      logic [SEG_WIDTH-1:0] pattern;
      case (digit)
         4'd0:    pattern = 8'h3f;
         4'd1:    pattern = 8'h06;
         4'd2:    pattern = 8'h5b;
         4'd3:    pattern = 8'h4f;
         4'd4:    pattern = 8'h66;
         4'd5:    pattern = 8'h6d;
         4'd6:    pattern = 8'h7d;
         4'd7:    pattern = 8'h07;
         4'd8:    pattern = 8'h7f;
         4'd9:    pattern = 8'h6f;
         default: pattern = DOT_ONLY;
      endcase
      return pattern;
   endfunction

endpackage

### design/urdc_phase_ctrl.sv
// Phase sequencer for the range controller: trigger, echo wait, echo measure
// and holdoff, with the tick and unit counters. Depends on urdc_pkg.
module urdc_phase_ctrl #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             tick_valid,
   input  logic             echo_level,
   input  urdc_pkg::cfg_type cfg,
   output urdc_pkg::rsp_type result
);

   localparam int CMP_WIDTH = ((COUNT_WIDTH > urdc_pkg::TICK_WIDTH) ?
                               COUNT_WIDTH : urdc_pkg::TICK_WIDTH) + 1;

   urdc_pkg::phase_type phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] phase_ticks_ff, phase_ticks_in;
   logic [urdc_pkg::UNIT_WIDTH-1:0] sub_ticks_ff, sub_ticks_in;
   logic [urdc_pkg::DIGIT_WIDTH-1:0] unit_count_ff, unit_count_in;
   logic [urdc_pkg::SEG_WIDTH-1:0] shown_segments_ff, shown_segments_in;
   logic shown_led_ff, shown_led_in;

   // Phase tick counter step, shared by the trigger and holdoff phases.
   logic [urdc_pkg::TICK_WIDTH-1:0] raw_limit;
   logic [CMP_WIDTH-1:0] limit_ext;
   logic [CMP_WIDTH-1:0] ticks_next;
   logic [CMP_WIDTH-1:0] count_mask;
   logic ticks_saturated;
   logic phase_over;
   logic [COUNT_WIDTH-1:0] ticks_stepped;

   // Echo unit counter step.
   logic [urdc_pkg::UNIT_WIDTH-1:0] unit_size;
   logic [urdc_pkg::UNIT_WIDTH:0] sub_next;
   logic unit_wrap;
   logic [urdc_pkg::UNIT_WIDTH-1:0] sub_after;
   logic [urdc_pkg::DIGIT_WIDTH-1:0] units_after;

   assign raw_limit = (phase_ff == urdc_pkg::PH_TRIGGER) ? cfg.trigger_ticks
                                                         : cfg.holdoff_ticks;
   assign limit_ext = (raw_limit == '0) ? CMP_WIDTH'(1)
                      : {{(CMP_WIDTH-urdc_pkg::TICK_WIDTH){1'b0}}, raw_limit};
   assign ticks_next = {{(CMP_WIDTH-COUNT_WIDTH){1'b0}}, phase_ticks_ff} + CMP_WIDTH'(1);
   assign count_mask = {{(CMP_WIDTH-COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};
   assign ticks_saturated = (ticks_next >= count_mask);
   assign phase_over = ticks_saturated || (ticks_next >= limit_ext);
   assign ticks_stepped = ticks_saturated ? {COUNT_WIDTH{1'b1}}
                                          : ticks_next[COUNT_WIDTH-1:0];

   // The wait phase starts a fresh count, so the step works from zero there.
   always_comb begin
      logic [urdc_pkg::UNIT_WIDTH-1:0] sub_base;
      logic [urdc_pkg::DIGIT_WIDTH-1:0] units_base;
      sub_base = (phase_ff == urdc_pkg::PH_WAIT) ? '0 : sub_ticks_ff;
      units_base = (phase_ff == urdc_pkg::PH_WAIT) ? '0 : unit_count_ff;
      unit_size = (cfg.ticks_per_unit == '0) ? urdc_pkg::UNIT_WIDTH'(1) : cfg.ticks_per_unit;
      sub_next = {1'b0, sub_base} + (urdc_pkg::UNIT_WIDTH+1)'(1);
      unit_wrap = (sub_next >= {1'b0, unit_size});
      sub_after = unit_wrap ? '0 : sub_next[urdc_pkg::UNIT_WIDTH-1:0];
      if (unit_wrap && (units_base < urdc_pkg::UNIT_MAX)) begin
         units_after = units_base + urdc_pkg::DIGIT_WIDTH'(1);
      end else begin
         units_after = units_base;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      phase_ticks_in = phase_ticks_ff;
      sub_ticks_in = sub_ticks_ff;
      unit_count_in = unit_count_ff;
      shown_segments_in = shown_segments_ff;
      shown_led_in = shown_led_ff;
      result.trigger_level = 1'b0;
      result.measure_done = 1'b0;
      case (phase_ff)
         urdc_pkg::PH_TRIGGER: begin
            result.trigger_level = 1'b1;
            phase_ticks_in = phase_over ? '0 : ticks_stepped;
            if (phase_over) begin
               phase_in = urdc_pkg::PH_WAIT;
            end
         end
         urdc_pkg::PH_WAIT: begin
            if (echo_level) begin
               phase_in = urdc_pkg::PH_MEASURE;
               sub_ticks_in = sub_after;
               unit_count_in = units_after;
            end
         end
         urdc_pkg::PH_MEASURE: begin
            if (echo_level) begin
               sub_ticks_in = sub_after;
               unit_count_in = units_after;
            end else begin
               if (unit_count_ff < urdc_pkg::UNIT_MAX) begin
                  shown_segments_in = urdc_pkg::digit_pattern(unit_count_ff);
                  shown_led_in = 1'b1;
               end else begin
                  shown_segments_in = urdc_pkg::DOT_ONLY;
                  shown_led_in = 1'b0;
               end
               result.measure_done = 1'b1;
               phase_ticks_in = '0;
               phase_in = (cfg.holdoff_ticks == '0) ? urdc_pkg::PH_TRIGGER
                                                    : urdc_pkg::PH_HOLDOFF;
            end
         end
         urdc_pkg::PH_HOLDOFF: begin
            phase_ticks_in = phase_over ? '0 : ticks_stepped;
            if (phase_over) begin
               phase_in = urdc_pkg::PH_TRIGGER;
            end
         end
         default: begin
            phase_in = urdc_pkg::PH_TRIGGER;
            phase_ticks_in = '0;
         end
      endcase
      result.segment_bits = shown_segments_in;
      result.led_on = shown_led_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= urdc_pkg::PH_TRIGGER;
         phase_ticks_ff <= '0;
         sub_ticks_ff <= '0;
         unit_count_ff <= '0;
         shown_segments_ff <= '0;
         shown_led_ff <= 1'b0;
      end else if (tick_valid) begin
         phase_ff <= phase_in;
         phase_ticks_ff <= phase_ticks_in;
         sub_ticks_ff <= sub_ticks_in;
         unit_count_ff <= unit_count_in;
         shown_segments_ff <= shown_segments_in;
         shown_led_ff <= shown_led_in;
      end
   end

endmodule

### design/urdc_out_buffer.sv
// Two-entry output buffer (result register plus skid register) for the
// range controller's result stream. Depends on urdc_pkg.
module urdc_out_buffer (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  urdc_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output urdc_pkg::rsp_type out_data
);

   logic out_valid_ff;
   urdc_pkg::rsp_type out_data_ff;
   logic skid_valid_ff;
   urdc_pkg::rsp_type skid_data_ff;
   logic in_take;
   logic out_take;

   assign in_ready = !skid_valid_ff;
   assign in_take = in_valid && in_ready;
   assign out_take = out_valid_ff && out_ready;
   assign out_valid = out_valid_ff;
   assign out_data = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_take) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end else if (in_take) begin
            out_data_ff <= in_data;
         end else begin
            out_valid_ff <= 1'b0;
         end
      end else if (in_take) begin
         if (!out_valid_ff) begin
            out_data_ff <= in_data;
            out_valid_ff <= 1'b1;
         end else begin
            skid_data_ff <= in_data;
            skid_valid_ff <= 1'b1;
         end
      end
   end

endmodule

### design/ultrasonic_range_digit_controller_core.sv
// Ultrasonic range finder controller with a one-digit seven-segment readout.
// Each request beat is one timer tick carrying the sampled echo level, and
// each one yields exactly one response beat with the trigger drive, the
// displayed segment pattern, the LED state and a flag marking the tick on
// which a new measurement appears. The block cycles through a trigger pulse,
// a wait for echo to rise, a measurement of the echo width in units of
// ticks_per_unit (saturating at ten), and a holdoff. Digits 0..9 show with
// the LED on; ten or more units show the dot alone with the LED off. A tick
// is taken in every clock cycle unless the request side stalls: the phase
// sequencer updates its state in the cycle the beat is accepted and the
// result is registered in a two-entry output buffer, so throughput is one
// beat per cycle without stalls. The request side stalls only while both
// entries hold unsent results. Configuration registers are written through
// the csr port and should only be changed while the block is idle.
// Depends on urdc_pkg, urdc_phase_ctrl and urdc_out_buffer.
module ultrasonic_range_digit_controller_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request stream. tdata: bit 0 echo_level, bits 7:1 zero.
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [urdc_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,
   // Response stream. tdata: bit 0 trigger_level, bits 8:1 segment_bits,
   // bit 9 led_on, bit 10 measure_done, bits 15:11 zero.
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [urdc_pkg::RSP_DATA_WIDTH-1:0]    rsp_tdata,
   // Configuration write port.
   input  logic                                   csr_we,
   input  logic [urdc_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [urdc_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   urdc_pkg::cfg_type cfg_ff;
   urdc_pkg::rsp_type tick_result;
   urdc_pkg::rsp_type buffered;
   logic tick_accept;

   // Configuration registers; indexes outside the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_ticks <= urdc_pkg::TRIGGER_TICKS_RESET;
         cfg_ff.holdoff_ticks <= urdc_pkg::HOLDOFF_TICKS_RESET;
         cfg_ff.ticks_per_unit <= urdc_pkg::TICKS_PER_UNIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            urdc_pkg::CSR_TRIGGER_TICKS: begin
               cfg_ff.trigger_ticks <= csr_wdata;
            end
            urdc_pkg::CSR_HOLDOFF_TICKS: begin
               cfg_ff.holdoff_ticks <= csr_wdata;
            end
            urdc_pkg::CSR_TICKS_PER_UNIT: begin
               cfg_ff.ticks_per_unit <= csr_wdata[urdc_pkg::UNIT_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // A tick advances the sequencer only on the beat that is accepted.
   assign tick_accept = req_tvalid && req_tready;

   urdc_phase_ctrl #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_phase_ctrl (
      .clock      (clock),
      .reset      (reset),
      .tick_valid (tick_accept),
      .echo_level (req_tdata[0]),
      .cfg        (cfg_ff),
      .result     (tick_result)
   );

   urdc_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (tick_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (buffered)
   );

   assign rsp_tdata = {5'b0, buffered.measure_done, buffered.led_on,
                       buffered.segment_bits, buffered.trigger_level};

endmodule

### verif/tb_top.sv
// Self-checking testbench for the ultrasonic range digit controller core.
// One timer tick per request beat, one response beat per tick, checked against
// a tick-accurate predictor kept here. Depends on urdc_pkg and the core.
`timescale 1ns / 1ps

module tb_top;

   // Phase count at which the counter saturates, at the default width.
   localparam int COUNT_FULL = (1 << urdc_pkg::TICK_WIDTH) - 1;
   // Digit patterns 0..9, digit 0 in the lowest byte, bit 0 is segment a.
   localparam logic [79:0] DIGIT_FONT = {
      8'h6f, 8'h7f, 8'h07, 8'h7d, 8'h6d, 8'h66, 8'h4f, 8'h5b, 8'h06, 8'h3f
   };
   localparam int PAD_LSB = $bits(urdc_pkg::rsp_type);

   // How the two sides of the stream idle during a phase of the run.
   typedef enum int {
      FLOW_FREE,
      FLOW_SENDER_GAPS,
      FLOW_RECEIVER_STALLS,
      FLOW_BOTH_BUSY
   } flow_mode_type;

   // Everything the controller remembers from one tick to the next.
   typedef struct packed {
      urdc_pkg::phase_type                  phase;
      logic [urdc_pkg::TICK_WIDTH-1:0]      phase_ticks;
      logic [urdc_pkg::UNIT_WIDTH-1:0]      sub_ticks;
      logic [urdc_pkg::DIGIT_WIDTH-1:0]     unit_count;
      logic [urdc_pkg::SEG_WIDTH-1:0]       segments;
      logic                                 led;
   } ranger_state_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   // Bit 0 echo_level, upper bits zero.
   logic [urdc_pkg::REQ_DATA_WIDTH-1:0]  req_tdata = '0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   // Bit 0 trigger_level, bits 8:1 segment_bits, bit 9 led_on, bit 10 measure_done.
   logic [urdc_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata;
   logic                                 csr_we = 1'b0;
   logic [urdc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [urdc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // Register values as the block holds them; only changed while the block is idle.
   urdc_pkg::cfg_type settings = {urdc_pkg::TRIGGER_TICKS_RESET,
                                  urdc_pkg::HOLDOFF_TICKS_RESET,
                                  urdc_pkg::TICKS_PER_UNIT_RESET};
   // The stimulus generator runs its own copy of the predictor ahead of the bus
   // so that it knows which phase each queued tick will land in.
   ranger_state_type plan_state;
   // The copy that follows the beats the block actually accepts.
   ranger_state_type dut_view;
   logic              tick_q[$];
   urdc_pkg::rsp_type expected_q[$];
   int                pulse_left = 0;
   flow_mode_type     flow = FLOW_FREE;
   int                error_count = 0;
   int                result_count = 0;

   always #5 clock = ~clock;

   ultrasonic_range_digit_controller_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Advances a trigger or holdoff count by one tick and reports whether the
   // phase is over. A zero length counts as one tick, and a count that reaches
   // its all-ones value ends the phase no matter what the length says.
   function automatic bit phase_elapsed(inout logic [urdc_pkg::TICK_WIDTH-1:0] ticks,
                                        input logic [urdc_pkg::TICK_WIDTH-1:0] length);
      int unsigned nxt;
      int unsigned lim;
      nxt = ticks + 32'd1;
      lim = (length == 0) ? 1 : length;
      if (nxt >= COUNT_FULL) begin
         ticks = urdc_pkg::TICK_WIDTH'(COUNT_FULL);
         return 1'b1;
      end
      ticks = urdc_pkg::TICK_WIDTH'(nxt);
      return nxt >= lim;
   endfunction

   // Counts one echo-high tick; a unit size of zero behaves as one, and the
   // unit count sticks at ten once it gets there.
   function automatic void count_echo(inout ranger_state_type st,
                                      input logic [urdc_pkg::UNIT_WIDTH-1:0] unit_size);
      int unsigned unit_len;
      unit_len = (unit_size == 0) ? 1 : unit_size;
      if (st.sub_ticks + 32'd1 >= unit_len) begin
         st.sub_ticks = '0;
         if (st.unit_count < urdc_pkg::UNIT_MAX)
            st.unit_count++;
      end else begin
         st.sub_ticks++;
      end
   endfunction

   // One timer tick: updates the state and gives the response beat it causes.
   function automatic void range_tick(inout ranger_state_type st,
                                      input urdc_pkg::cfg_type cfg,
                                      input logic echo, output urdc_pkg::rsp_type res);
      res = '0;
      case (st.phase)
         urdc_pkg::PH_TRIGGER: begin
            res.trigger_level = 1'b1;
            if (phase_elapsed(st.phase_ticks, cfg.trigger_ticks)) begin
               st.phase = urdc_pkg::PH_WAIT;
               st.phase_ticks = '0;
            end
         end
         urdc_pkg::PH_WAIT: begin
            // The tick on which echo rises is already the first counted one.
            if (echo) begin
               st.phase = urdc_pkg::PH_MEASURE;
               st.sub_ticks = '0;
               st.unit_count = '0;
               count_echo(st, cfg.ticks_per_unit);
            end
         end
         urdc_pkg::PH_MEASURE: begin
            if (echo) begin
               count_echo(st, cfg.ticks_per_unit);
            end else begin
               // Echo fell: the new reading shows on this very tick.
               if (st.unit_count < urdc_pkg::UNIT_MAX) begin
                  st.segments = DIGIT_FONT[st.unit_count * 8 +: 8];
                  st.led = 1'b1;
               end else begin
                  st.segments = urdc_pkg::DOT_ONLY;
                  st.led = 1'b0;
               end
               res.measure_done = 1'b1;
               st.phase_ticks = '0;
               st.phase = (cfg.holdoff_ticks == 0) ? urdc_pkg::PH_TRIGGER
                                                   : urdc_pkg::PH_HOLDOFF;
            end
         end
         default: begin
            if (phase_elapsed(st.phase_ticks, cfg.holdoff_ticks)) begin
               st.phase = urdc_pkg::PH_TRIGGER;
               st.phase_ticks = '0;
            end
         end
      endcase
      res.segment_bits = st.segments;
      res.led_on = st.led;
   endfunction

   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= 10)
         $display("%0t: %s", $realtime, what);
   endtask

   // Queues one tick for the driver and steps the planning copy of the state.
   task automatic push_tick(input logic echo, output urdc_pkg::rsp_type res);
      range_tick(plan_state, settings, echo, res);
      tick_q.push_back(echo);
   endtask

   // Queues shaped ticks. Echo pulses are drawn as a whole number of units
   // plus a remainder so that every digit and the out-of-range dot come up;
   // echo is random wherever the block ignores it, and with noise turned on an
   // occasional random level breaks a pulse or starts a stray one. A count of
   // zero means: run until two readings have been shown, which walks through
   // a complete trigger and holdoff whatever state the block starts in.
   task automatic queue_ticks(input int count, input int unit_lo, input int unit_hi,
                              input bit noisy);
      urdc_pkg::rsp_type res;
      logic              echo;
      int                made;
      int                dones;
      int unsigned       unit_len;
      made = 0;
      dones = 0;
      unit_len = (settings.ticks_per_unit == 0) ? 1 : settings.ticks_per_unit;
      while ((count != 0) ? (made < count) : (dones < 2)) begin
         if (plan_state.phase == urdc_pkg::PH_WAIT && pulse_left == 0 &&
             $urandom_range(2) == 0) begin
            pulse_left = $urandom_range(unit_hi, unit_lo) * unit_len
                         + $urandom_range(unit_len - 1);
            if (pulse_left == 0)
               pulse_left = 1;
         end
         if (plan_state.phase == urdc_pkg::PH_WAIT ||
             plan_state.phase == urdc_pkg::PH_MEASURE) begin
            echo = (pulse_left != 0);
            if (pulse_left != 0)
               pulse_left--;
         end else begin
            echo = 1'($urandom_range(1));
         end
         if (noisy && $urandom_range(11) == 0)
            echo = 1'($urandom_range(1));
         push_tick(echo, res);
         made++;
         if (res.measure_done)
            dones++;
      end
   endtask

   // Writes all three registers on consecutive cycles. Called only while idle.
   task automatic program_registers(input logic [urdc_pkg::TICK_WIDTH-1:0] trig_len,
                                    input logic [urdc_pkg::TICK_WIDTH-1:0] hold_len,
                                    input logic [urdc_pkg::UNIT_WIDTH-1:0] unit_size);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= urdc_pkg::CSR_TRIGGER_TICKS;
      csr_wdata <= trig_len;
      @(posedge clock);
      csr_index <= urdc_pkg::CSR_HOLDOFF_TICKS;
      csr_wdata <= hold_len;
      @(posedge clock);
      csr_index <= urdc_pkg::CSR_TICKS_PER_UNIT;
      csr_wdata <= {{(urdc_pkg::CSR_DATA_WIDTH - urdc_pkg::UNIT_WIDTH){1'b0}}, unit_size};
      @(posedge clock);
      csr_we <= 1'b0;
      settings.trigger_ticks = trig_len;
      settings.holdoff_ticks = hold_len;
      settings.ticks_per_unit = unit_size;
      @(negedge clock);
   endtask

   // Holds the sender back until every queued tick has gone out and every
   // response beat it caused has been checked. Every tick yields a beat, so
   // nothing is still in flight inside the block once this returns.
   task automatic wait_idle();
      @(negedge clock);
      while (tick_q.size() != 0 || req_tvalid || expected_q.size() != 0)
         @(negedge clock);
   endtask

   // Request driver. The prediction is made for the beat that was on the bus
   // at this edge when the block accepted it; then the next tick is offered,
   // unless the current flow mode calls for a gap.
   always @(posedge clock) begin : drive_ticks
      urdc_pkg::rsp_type predicted;
      logic              next_echo;
      bit                gap;
      gap = (flow == FLOW_SENDER_GAPS) ? ($urandom_range(99) < 69) :
            (flow == FLOW_BOTH_BUSY)   ? ($urandom_range(99) < 25) : 1'b0;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            range_tick(dut_view, settings, req_tdata[0], predicted);
            expected_q.push_back(predicted);
         end
         if (!req_tvalid || req_tready) begin
            if (tick_q.size() != 0 && !gap) begin
               next_echo = tick_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {{(urdc_pkg::REQ_DATA_WIDTH - 1){1'b0}}, next_echo};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and back-pressure. Each accepted beat is compared field
   // by field with the oldest prediction; the padding bits must be zero.
   always @(posedge clock) begin : check_results
      urdc_pkg::rsp_type seen;
      urdc_pkg::rsp_type wanted;
      bit                stall;
      stall = (flow == FLOW_RECEIVER_STALLS) ? ($urandom_range(99) < 69) :
              (flow == FLOW_BOTH_BUSY)       ? ($urandom_range(99) < 25) : 1'b0;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !stall;
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_tdata[PAD_LSB-1:0];
            if (expected_q.size() == 0) begin
               flag_error($sformatf("response beat %0d arrived with nothing expected",
                                    result_count));
            end else begin
               wanted = expected_q.pop_front();
               if (seen.trigger_level !== wanted.trigger_level ||
                   seen.segment_bits !== wanted.segment_bits ||
                   seen.led_on !== wanted.led_on ||
                   seen.measure_done !== wanted.measure_done ||
                   rsp_tdata[urdc_pkg::RSP_DATA_WIDTH-1:PAD_LSB] !== '0)
                  flag_error($sformatf({"beat %0d mismatch (exp/act): trigger %0b/%0b ",
                     "segments %02h/%02h led %0b/%0b done %0b/%0b pad 0/%0h"},
                     result_count, wanted.trigger_level, seen.trigger_level,
                     wanted.segment_bits, seen.segment_bits, wanted.led_on, seen.led_on,
                     wanted.measure_done, seen.measure_done,
                     rsp_tdata[urdc_pkg::RSP_DATA_WIDTH-1:PAD_LSB]));
            end
            result_count++;
         end
      end
   end

   // Test sequence. Each phase starts from an idle block; all but the first
   // reprogram all registers, and then each queues its ticks.
   initial begin : run_phases
      int                p;
      int                i;
      logic [15:0]       opening;
      urdc_pkg::rsp_type unused;
      plan_state = '0;
      plan_state.phase = urdc_pkg::PH_TRIGGER;
      dut_view = plan_state;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values first: ten trigger ticks with echo toggling (it must be
      // ignored there), then two quiet ticks in the wait phase.
      for (i = 0; i < 12; i++)
         push_tick(i < 10 && i % 2 == 0, unused);
      wait_idle();

      // Zero lengths everywhere: a one-tick trigger, no holdoff, one tick per
      // unit. Sequence: a trigger tick with echo high, a quiet tick in the wait
      // phase, an echo long enough to saturate (dot only, LED off), and one
      // more trigger tick.
      program_registers('0, '0, '0);
      opening = 16'b0011_1111_1111_1101;
      for (i = 0; i < 16; i++)
         push_tick(opening[i], unused);
      wait_idle();

      // Longer lengths at full speed: a complete trigger and holdoff, with
      // echoes that always saturate the unit count.
      program_registers(16'd60, 16'd50, 8'd9);
      queue_ticks(0, 11, 11, 1'b0);
      wait_idle();

      // Short random settings under every combination of gaps and stalls.
      for (p = 0; p < 8; p++) begin
         program_registers(urdc_pkg::TICK_WIDTH'($urandom_range(5)),
                           urdc_pkg::TICK_WIDTH'($urandom_range(8)),
                           urdc_pkg::UNIT_WIDTH'($urandom_range(5)));
         flow = flow_mode_type'(p % 4);
         queue_ticks(120, 0, 11, 1'b1);
         wait_idle();
      end

      flow = FLOW_FREE;
      repeat (8) @(posedge clock);
      if (expected_q.size() != 0)
         flag_error($sformatf("%0d response beats never arrived", expected_q.size()));
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // Watchdog: well beyond the slowest legal run of the sequence above.
   initial begin : watchdog
      #10ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

### ultrasonic_range_digit_controller_core.f
design/urdc_pkg.sv
design/urdc_phase_ctrl.sv
design/urdc_out_buffer.sv
design/ultrasonic_range_digit_controller_core.sv
verif/tb_top.sv
